// ===== sv/ucs_pkg.sv =====
package ucs_pkg;

    // Byte codes used by the converter
    localparam logic [7:0] ASCII_NUL      = 8'h00;
    localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z  = 8'h7A;
    localparam logic [7:0] ASCII_CASE_BIT = 8'h20;
    localparam logic [7:0] ASCII_UPPER_I  = 8'h49;

    // UTF-8 lead byte classes
    localparam logic [7:0] CONT_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Dotless small i collapses to a plain capital I
    localparam logic [15:0] DOTLESS_I = 16'hC4B1;

    localparam logic [15:0] CAPACITY_RESET = 16'd256;

    // One queue entry: the beats caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] data;    // data bytes, lowest index first
        logic [2:0]      n_data;  // data beats, 0 to 4
        logic            term;    // a terminator beat follows the data
        logic [15:0]     base;    // bytes written before this entry
    } burst_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Expected sequence length from the lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = 3'd4;
        else
            len = 3'd1;
        return len;
    endfunction

    // Two-byte lowercase letters and their capitals; others pass unchanged
    function automatic logic [15:0] fold_pair(input logic [15:0] pair);
        logic [15:0] res;
        case (pair)
            16'hC3A7: res = 16'hC387;
            16'hC3B6: res = 16'hC396;
            16'hC3BC: res = 16'hC39C;
            16'hC49F: res = 16'hC49E;
            16'hC59F: res = 16'hC59E;
            16'hC3A2: res = 16'hC382;
            16'hC3AE: res = 16'hC38E;
            16'hC3BB: res = 16'hC39B;
            default:  res = pair;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/ucs_front.sv =====
module ucs_front
    import ucs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  q_status_t   q_stat,
    output logic        q_push,
    output burst_t      q_wdata
);

    logic [15:0] cap_reg,  cap_next;
    logic [7:0]  pend_reg [3];
    logic [7:0]  pend_next [3];
    logic [1:0]  pcnt_reg, pcnt_next;
    logic [2:0]  seq_reg,  seq_next;
    logic [15:0] bw_reg,   bw_next;
    logic        stop_reg, stop_next;

    logic            acc;
    logic [7:0]      ub;
    logic [2:0]      lead;
    logic            em_req;
    logic [2:0]      em_cnt;
    logic [3:0][7:0] em_data;
    logic            em_fits;
    logic            tail_fits;
    logic [15:0]     pair;
    logic [15:0]     folded;

    assign in_ready = !q_stat.full;
    assign acc      = in_valid && in_ready;

    // Classification of the incoming byte
    assign lead = lead_length(in_byte);
    assign ub   = (in_byte >= ASCII_LOWER_A && in_byte <= ASCII_LOWER_Z)
                  ? (in_byte - ASCII_CASE_BIT) : in_byte;
    assign pair   = {pend_reg[0], in_byte};
    assign folded = fold_pair(pair);

    // Fit check for a cut-off tail, one bit wider to avoid wrap
    assign tail_fits = ({1'b0, bw_reg} + 17'(seq_reg)) < {1'b0, cap_reg};

    // Sequence tracking and beat generation
    always_comb
    begin
        cap_next  = cfg_we ? cfg_wdata : cap_reg;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        seq_next  = seq_reg;
        bw_next   = bw_reg;
        stop_next = stop_reg;
        q_push    = 1'b0;
        q_wdata   = '0;
        em_req    = 1'b0;
        em_cnt    = 3'd0;
        em_data   = '0;
        em_fits   = 1'b0;

        if (acc)
        begin
            if (in_byte == ASCII_NUL)
            begin
                // End of string: push the terminator, after a partial sequence if it would fit
                if (!stop_reg)
                begin
                    q_push       = 1'b1;
                    q_wdata.term = 1'b1;
                    q_wdata.base = bw_reg;
                    if (seq_reg != 3'd0 && tail_fits)
                    begin
                        q_wdata.n_data  = {1'b0, pcnt_reg};
                        q_wdata.data[0] = pend_reg[0];
                        q_wdata.data[1] = pend_reg[1];
                        q_wdata.data[2] = pend_reg[2];
                    end
                end
                pend_next = '{default: 8'h00};
                pcnt_next = 2'd0;
                seq_next  = 3'd0;
                bw_next   = 16'd0;
                stop_next = 1'b0;
            end
            else if (stop_reg)
            begin
                // dropped until the end of the string
            end
            else if (seq_reg == 3'd0)
            begin
                if (lead == 3'd1)
                begin
                    em_req     = 1'b1;
                    em_cnt     = 3'd1;
                    em_data[0] = ub;
                end
                else
                begin
                    pend_next[0] = ub;
                    pcnt_next    = 2'd1;
                    seq_next     = lead;
                end
            end
            else if (({1'b0, pcnt_reg} + 3'd1) < seq_reg)
            begin
                pend_next[pcnt_reg] = in_byte;
                pcnt_next           = pcnt_reg + 2'd1;
            end
            else
            begin
                // Sequence complete
                em_req = 1'b1;
                if (seq_reg == 3'd2)
                begin
                    if (pair == DOTLESS_I)
                    begin
                        em_cnt     = 3'd1;
                        em_data[0] = ASCII_UPPER_I;
                    end
                    else
                    begin
                        em_cnt     = 3'd2;
                        em_data[0] = folded[15:8];
                        em_data[1] = folded[7:0];
                    end
                end
                else
                begin
                    em_cnt     = {1'b0, pcnt_reg} + 3'd1;
                    em_data[0] = pend_reg[0];
                    em_data[1] = (pcnt_reg == 2'd1) ? in_byte : pend_reg[1];
                    em_data[2] = (pcnt_reg == 2'd2) ? in_byte : pend_reg[2];
                    em_data[3] = in_byte;
                end
                pend_next = '{default: 8'h00};
                pcnt_next = 2'd0;
                seq_next  = 3'd0;
            end

            // Write a whole character or stop with the terminator
            if (em_req)
            begin
                // one bit wider to avoid wrap
                em_fits      = ({1'b0, bw_reg} + 17'(em_cnt)) < {1'b0, cap_reg};
                q_push       = 1'b1;
                q_wdata.base = bw_reg;
                if (em_fits)
                begin
                    q_wdata.n_data = em_cnt;
                    q_wdata.data   = em_data;
                    bw_next        = bw_reg + 16'(em_cnt);
                end
                else
                begin
                    q_wdata.term = 1'b1;
                    stop_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAPACITY_RESET;
            pend_reg <= '{default: 8'h00};
            pcnt_reg <= 2'd0;
            seq_reg  <= 3'd0;
            bw_reg   <= 16'd0;
            stop_reg <= 1'b0;
        end
        else
        begin
            cap_reg  <= cap_next;
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            seq_reg  <= seq_next;
            bw_reg   <= bw_next;
            stop_reg <= stop_next;
        end
    end

endmodule

// ===== sv/ucs_queue.sv =====
module ucs_queue
    import ucs_pkg::*;
#(
    parameter int unsigned Depth = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  burst_t    wdata,
    input  logic      pop,
    output burst_t    head,
    output q_status_t stat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    burst_t          mem [Depth];
    logic [PtrW-1:0] wp_reg, wp_next;
    logic [PtrW-1:0] rp_reg, rp_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign head       = mem[rp_reg];
    assign stat.full  = (cnt_reg == FullCnt);
    assign stat.empty = (cnt_reg == '0);

    // Pointer and fill count update
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == LastPtr) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == LastPtr) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

endmodule

// ===== sv/ucs_back.sv =====
module ucs_back
    import ucs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  burst_t      head,
    input  q_status_t   q_stat,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [15:0] written
);

    logic [2:0]  idx_reg,   idx_next;
    logic        ov_reg,    ov_next;
    logic [7:0]  ob_reg,    ob_next;
    logic        last_reg,  last_next;
    logic [15:0] wr_reg,    wr_next;

    logic       load;
    logic       is_data;
    logic       final_beat;
    logic [2:0] total;

    assign total      = head.n_data + {2'b00, head.term};
    assign is_data    = idx_reg < head.n_data;
    assign final_beat = (idx_reg == total - 3'd1);
    assign load       = !ov_reg || out_ready;
    assign q_pop      = load && !q_stat.empty && final_beat;

    // Walk the head entry one beat at a time into the output register
    always_comb
    begin
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        last_next = last_reg;
        wr_next   = wr_reg;
        if (load)
        begin
            ov_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                if (is_data)
                begin
                    ob_next   = head.data[idx_reg[1:0]];
                    last_next = 1'b0;
                    wr_next   = head.base + 16'(idx_reg) + 16'd1;
                end
                else
                begin
                    ob_next   = ASCII_NUL;
                    last_next = 1'b1;
                    wr_next   = head.base + 16'(head.n_data);
                end
                idx_next = final_beat ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg   <= ob_next;
        last_reg <= last_next;
        wr_reg   <= wr_next;
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign last      = last_reg;
    assign written   = wr_reg;

endmodule

// ===== sv/utf8_uppercase_stream.sv =====
// Path: the input byte that completes a result is written into a queue entry, and
// its first beat then goes to the back end's output register when the queue was empty.
// Throughput: one input byte per cycle while the queue between front and back
// has room; the back end sends one beat per cycle unless out_ready stalls it, so a
// byte yielding k beats holds the output and the queue (QueueDepth entries) absorbs it.
// Reset: capacity returns to 256, string state clears and the queue empties.
module utf8_uppercase_stream
    import ucs_pkg::*;
#(
    parameter int unsigned QueueDepth = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [15:0] written
);

    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;
    burst_t    q_wdata;
    burst_t    q_head;

    // Front end: decode and fit checks
    ucs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // Queue of per-byte beat groups
    ucs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    // Back end: serialise beats to the output
    ucs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last),
        .written   (written)
    );

    // Checks
    a_term_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_byte == ASCII_NUL)
        else $error("terminator beat carries a nonzero byte");

    a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> written != 16'd0)
        else $error("data beat with zero written count");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !q_pop)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_push)
        else $error("queue pushed while full");

endmodule
